// File: hdl/three_wire_rtc_register_access_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three-wire RTC register access block
// Clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_REGISTER_ACCESS_DEFINES_SVH
`define THREE_WIRE_RTC_REGISTER_ACCESS_DEFINES_SVH

// Same-cycle implication.
`define RTCRA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtcra assertion failed");

// Next-cycle implication.
`define RTCRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtcra assertion failed");

`endif

// File: hdl/rtcra_pkg.sv
// ---------------------------------------------------------------------------
// rtcra_pkg
// Types, constants and helpers shared by the RTC register access block.
// ---------------------------------------------------------------------------
package rtcra_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_DEPTH       = 2;

    localparam logic [5:0] LAST_PHASE    = 6'd33;
    // First phase that carries the data byte (bit 8 setup)
    localparam logic [5:0] DATA_PHASE    = 6'd17;
    localparam logic [6:0] MAX_WR_VALUE  = 7'd99;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_kind;

    typedef struct packed {
        t_req_kind   kind;
        logic [7:0]  cmd;
        logic [7:0]  bcd;
        logic        sda;
    } t_item;

    typedef struct packed {
        logic        rst_pin;
        logic        sck_pin;
        logic        sda_out;
        logic        sda_drive;
        logic        busy;
        logic        done;
        logic [7:0]  read_value;
    } t_result;

    // Clamp to 99 and split into two BCD digits (divide by 10 via reciprocal)
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] value);
        logic [6:0]  v;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        v    = (value > MAX_WR_VALUE) ? MAX_WR_VALUE : value;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
        return {tens, ones[3:0]};
    endfunction

    // High nibble times ten plus low nibble
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] bcd);
        logic [7:0] hi;
        hi = {4'b0000, bcd[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, bcd[3:0]};
    endfunction

endpackage

// File: hdl/rtcra_front.sv
// ---------------------------------------------------------------------------
// rtcra_front
// Accepts transactions, classifies them and queues them for the engine.
// ---------------------------------------------------------------------------
module rtcra_front
    import rtcra_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_cmd_addr,
    input  logic [6:0]  i_wr_value,
    input  logic        i_sda_in,
    output logic        o_item_valid,
    input  logic        i_item_take,
    output t_item       o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    t_item              w_class;
    logic               w_push, w_pop;

    always_comb begin
        w_class.sda  = i_sda_in;
        w_class.cmd  = i_cmd_addr;
        w_class.bcd  = 8'h00;
        w_class.kind = REQ_NONE;
        unique case (t_req_kind'(i_req_type))
            REQ_TICK: begin
                w_class.kind = REQ_TICK;
            end
            REQ_WRITE: begin
                w_class.kind = REQ_WRITE;
                w_class.cmd  = {i_cmd_addr[7:1], 1'b0};
                w_class.bcd  = bin_to_bcd(i_wr_value);
            end
            REQ_READ: begin
                w_class.kind = REQ_READ;
                w_class.cmd  = {i_cmd_addr[7:1], 1'b1};
            end
            default: begin
                w_class.kind = REQ_NONE;
            end
        endcase
    end

    assign full         = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_push       = push && !full;
    assign w_pop        = o_item_valid && i_item_take;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

// File: hdl/rtcra_engine.sv
// ---------------------------------------------------------------------------
// rtcra_engine
// Steps the pins one item per cycle into a result buffer while it has room.
// ---------------------------------------------------------------------------
module rtcra_engine
    import rtcra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    output logic        o_item_take,
    input  t_item       i_item,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result
);

    localparam int OPTR_W = $clog2(OUT_DEPTH);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    logic [5:0]   r_phase, n_phase;
    logic [15:0]  r_out_shift, n_out_shift;
    logic [7:0]   r_in_shift, n_in_shift;
    logic         r_read_mode, n_read_mode;
    logic         r_busy, n_busy;
    logic [3:0]   r_pins, n_pins;      // {drive, sda, sck, rst}
    logic         w_done;
    logic [7:0]   w_rv;
    logic         w_adv, w_pop;
    t_result      w_res;

    t_result            r_obuf [OUT_DEPTH];
    logic [OPTR_W-1:0]  r_owr, r_ord;
    logic [OCNT_W-1:0]  r_ocnt;

    assign w_pop       = pop && !empty;
    assign o_item_take = (r_ocnt != OCNT_W'(OUT_DEPTH)) || w_pop;
    assign w_adv       = i_item_valid && o_item_take;
    assign empty       = (r_ocnt == '0);
    assign o_result    = r_obuf[r_ord];

    always_comb begin
        n_phase     = r_phase;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_read_mode = r_read_mode;
        n_busy      = r_busy;
        n_pins      = r_pins;
        w_done      = 1'b0;
        w_rv        = 8'h00;
        case (i_item.kind) inside
            REQ_WRITE, REQ_READ: begin
                if (!r_busy) begin
                    n_read_mode = (i_item.kind == REQ_READ);
                    n_out_shift = (i_item.kind == REQ_READ) ? {8'h00, i_item.cmd}
                                                            : {i_item.bcd, i_item.cmd};
                    n_in_shift  = 8'h00;
                    n_phase     = 6'd0;
                    n_busy      = 1'b1;
                    n_pins      = 4'b0000;
                end
            end
            REQ_TICK: begin
                if (r_busy) begin
                    n_phase = r_phase + 1'b1;
                    if (r_phase == 6'd0) begin
                        n_pins = 4'b0001;
                    end else if (r_phase < LAST_PHASE) begin
                        if (r_phase[0]) begin
                            // setup phase: clock low
                            if (r_read_mode && (r_phase >= DATA_PHASE)) begin
                                n_in_shift = {i_item.sda, r_in_shift[7:1]};
                                n_pins     = 4'b0001;
                            end else begin
                                n_pins = {1'b1, r_out_shift[0], 2'b01};
                            end
                        end else begin
                            // clock high, data held
                            n_pins      = {r_pins[3:2], 2'b11};
                            n_out_shift = {1'b0, r_out_shift[15:1]};
                        end
                    end else begin
                        n_pins = 4'b0000;
                        w_done = 1'b1;
                        n_busy = 1'b0;
                        if (r_read_mode) begin
                            w_rv = bcd_to_bin(r_in_shift);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_res.rst_pin    = n_pins[0];
        w_res.sck_pin    = n_pins[1];
        w_res.sda_out    = n_pins[2];
        w_res.sda_drive  = n_pins[3];
        w_res.busy       = n_busy;
        w_res.done       = w_done;
        w_res.read_value = w_rv;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_obuf[r_owr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_shift <= '0;
            r_in_shift  <= '0;
            r_read_mode <= 1'b0;
            r_busy      <= 1'b0;
            r_pins      <= '0;
            r_owr       <= '0;
            r_ord       <= '0;
            r_ocnt      <= '0;
        end else begin
            if (w_adv) begin
                r_phase     <= n_phase;
                r_out_shift <= n_out_shift;
                r_in_shift  <= n_in_shift;
                r_read_mode <= n_read_mode;
                r_busy      <= n_busy;
                r_pins      <= n_pins;
                r_owr       <= (r_owr == OPTR_W'(OUT_DEPTH - 1)) ? '0 : r_owr + 1'b1;
            end
            if (w_pop) begin
                r_ord <= (r_ord == OPTR_W'(OUT_DEPTH - 1)) ? '0 : r_ord + 1'b1;
            end
            if (w_adv && !w_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (!w_adv && w_pop) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

endmodule

// File: hdl/three_wire_rtc_register_access.sv
// Path: a pushed transaction is registered in the front queue, then its result
// in the engine's result buffer, from which it drives the result ports.
// Throughput: one transaction per cycle while the result buffer has room or is popped.
// Reset: synchronous, active low; clears both queues, the phase counter, the
// shift registers and the pin levels (all low, data line released).
// ---------------------------------------------------------------------------
// three_wire_rtc_register_access
// Master side of a three-wire serial register access: request transactions
// start a one-register write or read, tick transactions walk the pins.
// ---------------------------------------------------------------------------
module three_wire_rtc_register_access
    import rtcra_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF    // front queue entries, 2 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_cmd_addr,
    input  logic [6:0]  i_wr_value,
    input  logic        i_sda_in,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic        o_rst_pin,
    output logic        o_sck_pin,
    output logic        o_sda_out,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_value
);

    // Classified transaction between front and engine
    logic     w_item_valid;
    logic     w_item_take;
    t_item    w_item;
    t_result  w_result;

    // Front: forces the command read/write bit, converts the write value to
    // BCD (clamped to 99) and queues the transaction.
    rtcra_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_cmd_addr   (i_cmd_addr),
        .i_wr_value   (i_wr_value),
        .i_sda_in     (i_sda_in),
        .o_item_valid (w_item_valid),
        .i_item_take  (w_item_take),
        .o_item       (w_item)
    );

    // Engine: 34 ticks per register access (enable rise, 16 bits at two ticks each,
    // enable fall). Results land in a two-entry buffer so the engine keeps running
    // while the oldest result waits to be popped, until the buffer is full.
    rtcra_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_take  (w_item_take),
        .i_item       (w_item),
        .empty        (empty),
        .pop          (pop),
        .o_result     (w_result)
    );

    assign o_rst_pin    = w_result.rst_pin;
    assign o_sck_pin    = w_result.sck_pin;
    assign o_sda_out    = w_result.sda_out;
    assign o_sda_drive  = w_result.sda_drive;
    assign o_busy_res   = w_result.busy;
    assign o_done_res   = w_result.done;
    assign o_read_value = w_result.read_value;

endmodule

// File: hdl/rtcra_checker.sv
// ---------------------------------------------------------------------------
// rtcra_checker
// Port-level checks on the result stream of the RTC register access block.
// ---------------------------------------------------------------------------
`include "three_wire_rtc_register_access_defines.svh"

module rtcra_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic        o_rst_pin,
    input  logic        o_sck_pin,
    input  logic        o_sda_out,
    input  logic        o_sda_drive,
    input  logic        o_busy_res,
    input  logic        o_done_res,
    input  logic [7:0]  o_read_value
);

    // end of transaction leaves the engine idle with enable and clock low
    `RTCRA_ASSERT_NOW(a_done_idle, !empty && o_done_res, !o_busy_res && !o_rst_pin && !o_sck_pin)
    // clock only toggles while enable is high
    `RTCRA_ASSERT_NOW(a_sck_rst, !empty && o_sck_pin, o_rst_pin && o_busy_res)
    // released data line reads as low
    `RTCRA_ASSERT_NOW(a_release_low, !empty && !o_sda_drive, !o_sda_out)
    // read data only on the done tick, and never above 165
    `RTCRA_ASSERT_NOW(a_rv_done, !empty && (o_read_value != 8'd0), o_done_res && (o_read_value <= 8'd165))
    // a result on display stays until popped
    `RTCRA_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_done_res) && $stable(o_read_value))

endmodule

bind three_wire_rtc_register_access rtcra_checker u_rtcra_checker (.*);

// File: bench/rtc_pin_sequence_checker.sv
// ---------------------------------------------------------------------------
// rtc_pin_sequence_checker
// Watches both queue sides of the three-wire RTC access block. It predicts the
// pin levels, busy/done flags and read value for every accepted transaction,
// then compares each popped result field by field against the oldest one.
// ---------------------------------------------------------------------------
module rtc_pin_sequence_checker
    import rtcra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_cmd_addr,
    input  logic [6:0]  i_wr_value,
    input  logic        i_sda_in,
    // result side
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_rst_pin,
    input  logic        i_sck_pin,
    input  logic        i_sda_out,
    input  logic        i_sda_drive,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic [7:0]  i_read_value,
    // status to the top
    output int          o_pending,
    output int          o_mismatches
);

    localparam logic [5:0] END_PHASE = 6'd33;

    t_result    pin_results_q[$];
    int         mismatches = 0;

    // predicted sequencer state
    logic [5:0]  seq_phase;
    logic [15:0] tx_bits;
    logic        rd_mode;
    logic        seq_busy;
    logic [7:0]  rx_bits;
    logic        pin_rst;
    logic        pin_sck;
    logic        pin_sda;
    logic        pin_drv;

    assign o_mismatches = mismatches;

    // One transaction in, one predicted result out.
    task automatic step_pin_sequencer(input t_req_kind kind, input logic [7:0] cmd,
                                      input logic [6:0] wval, input logic sda);
        t_result    res;
        logic [6:0] v;
        logic [3:0] bit_idx;
        res = '0;
        if (!seq_busy && (kind == REQ_WRITE || kind == REQ_READ)) begin
            if (kind == REQ_WRITE) begin
                v       = (wval > 7'd99) ? 7'd99 : wval;
                tx_bits = {4'(v / 10), 4'(v % 10), cmd & 8'hFE};
                rd_mode = 1'b0;
            end else begin
                tx_bits = {8'h00, cmd | 8'h01};
                rd_mode = 1'b1;
            end
            rx_bits   = '0;
            seq_phase = '0;
            seq_busy  = 1'b1;
            {pin_rst, pin_sck, pin_sda, pin_drv} = 4'b0000;
        end else if (kind == REQ_TICK && seq_busy) begin
            if (seq_phase == 6'd0) begin
                {pin_rst, pin_sck, pin_sda, pin_drv} = 4'b1000;
            end else if (seq_phase < END_PHASE) begin
                bit_idx = 4'((seq_phase - 6'd1) >> 1);
                if (seq_phase[0]) begin
                    // setup half: drive next bit, or sample when released
                    if (rd_mode && bit_idx[3]) begin
                        rx_bits = {sda, rx_bits[7:1]};
                        {pin_rst, pin_sck, pin_sda, pin_drv} = 4'b1000;
                    end else begin
                        {pin_rst, pin_sck, pin_sda, pin_drv} = {2'b10, tx_bits[0], 1'b1};
                    end
                end else begin
                    // clock high, data line holds
                    pin_rst = 1'b1;
                    pin_sck = 1'b1;
                    tx_bits = tx_bits >> 1;
                end
            end else begin
                {pin_rst, pin_sck, pin_sda, pin_drv} = 4'b0000;
                res.done = 1'b1;
                seq_busy = 1'b0;
                if (rd_mode)
                    res.read_value = 8'(rx_bits[7:4] * 10 + rx_bits[3:0]);
            end
            seq_phase = seq_phase + 6'd1;
        end
        res.rst_pin   = pin_rst;
        res.sck_pin   = pin_sck;
        res.sda_out   = pin_sda;
        res.sda_drive = pin_drv;
        res.busy      = seq_busy;
        pin_results_q.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result exp_r;
        if (!i_rst_n) begin
            pin_results_q.delete();
            seq_phase = '0;
            tx_bits   = '0;
            rd_mode   = 1'b0;
            seq_busy  = 1'b0;
            rx_bits   = '0;
            {pin_rst, pin_sck, pin_sda, pin_drv} = 4'b0000;
        end else begin
            // results first, so a stray pop never meets this edge's push
            if (i_pop && !i_empty) begin
                if (pin_results_q.size() == 0) begin
                    $display("%0t: result with no transaction waiting, rst=%b sck=%b sda=%b",
                             $time, i_rst_pin, i_sck_pin, i_sda_out);
                    mismatches++;
                end else begin
                    exp_r = pin_results_q.pop_front();
                    check_field("rst_pin",    8'(exp_r.rst_pin),   8'(i_rst_pin));
                    check_field("sck_pin",    8'(exp_r.sck_pin),   8'(i_sck_pin));
                    check_field("sda_out",    8'(exp_r.sda_out),   8'(i_sda_out));
                    check_field("sda_drive",  8'(exp_r.sda_drive), 8'(i_sda_drive));
                    check_field("busy_res",   8'(exp_r.busy),      8'(i_busy_res));
                    check_field("done_res",   8'(exp_r.done),      8'(i_done_res));
                    check_field("read_value", exp_r.read_value,    i_read_value);
                end
            end
            if (i_push && !i_full)
                step_pin_sequencer(t_req_kind'(i_req_type), i_cmd_addr, i_wr_value, i_sda_in);
        end
        o_pending = pin_results_q.size();
    end

endmodule

// File: bench/tb_three_wire_rtc_register_access.sv
// ---------------------------------------------------------------------------
// tb_three_wire_rtc_register_access
// Drives write/read requests and pin-phase ticks into the three-wire RTC
// access block and lets the checker compare every popped result.
// ---------------------------------------------------------------------------
module tb_three_wire_rtc_register_access;
    import rtcra_pkg::*;

    // Cycle limit for the watchdog, far beyond the slowest legal run.
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PHASE_ITEMS   = 100;     // random transactions per idling phase
    localparam int TICKS_PER_TX  = 34;      // phases 0..33 of one register access

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [1:0]  i_req_type   = 2'd0;
    logic [7:0]  i_cmd_addr   = 8'd0;
    logic [6:0]  i_wr_value   = 7'd0;
    logic        i_sda_in     = 1'b0;
    logic        empty;
    logic        pop          = 1'b0;
    logic        o_rst_pin;
    logic        o_sck_pin;
    logic        o_sda_out;
    logic        o_sda_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_value;

    int          pending;
    int          mismatch_cnt;
    int          sent_cnt     = 0;
    int          cycle_cnt    = 0;
    int          send_idle_pct = 36;
    int          recv_idle_pct = 45;

    // 20-unit clock period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    three_wire_rtc_register_access DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_cmd_addr   (i_cmd_addr),
        .i_wr_value   (i_wr_value),
        .i_sda_in     (i_sda_in),
        .empty        (empty),
        .pop          (pop),
        .o_rst_pin    (o_rst_pin),
        .o_sck_pin    (o_sck_pin),
        .o_sda_out    (o_sda_out),
        .o_sda_drive  (o_sda_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_value (o_read_value)
    );

    rtc_pin_sequence_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_req_type   (i_req_type),
        .i_cmd_addr   (i_cmd_addr),
        .i_wr_value   (i_wr_value),
        .i_sda_in     (i_sda_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_rst_pin    (o_rst_pin),
        .i_sck_pin    (o_sck_pin),
        .i_sda_out    (o_sda_out),
        .i_sda_drive  (o_sda_drive),
        .i_busy_res   (o_busy_res),
        .i_done_res   (o_done_res),
        .i_read_value (o_read_value),
        .o_pending    (pending),
        .o_mismatches (mismatch_cnt)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: pop is re-rolled every falling edge, so stalls land on
    // every phase of the pin sequence.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Push one transaction. Entered and left on a falling edge. While the
    // sender idles the payload ports carry junk that must be ignored.
    task automatic send_item(input t_req_kind kind, input logic [7:0] cmd,
                             input logic [6:0] wval, input logic sda);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push       <= 1'b0;
            i_req_type <= 2'($urandom_range(0, 3));
            i_cmd_addr <= 8'($urandom);
            i_wr_value <= 7'($urandom);
            i_sda_in   <= 1'($urandom);
            @(negedge i_clk);
        end
        push       <= 1'b1;
        i_req_type <= kind;
        i_cmd_addr <= cmd;
        i_wr_value <= wval;
        i_sda_in   <= sda;
        // accepted at the first rising edge where full is low
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        sent_cnt++;
    endtask

    // Walk the pins with n_ticks ticks. On a read, the data phases get the
    // bits of rd_byte (LSB first) on the setup half where the line is sampled.
    // noise_pct mixes in requests and no-op kinds that a busy block ignores.
    task automatic clock_out(input logic rd, input logic [7:0] rd_byte,
                             input int n_ticks, input int noise_pct);
        logic sda;
        for (int p = 0; p < n_ticks; p++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(t_req_kind'($urandom_range(1, 3)), 8'($urandom),
                          7'($urandom), 1'($urandom));
            sda = 1'($urandom);
            if (rd && p[0] && p >= 17 && p <= 31)
                sda = rd_byte[(p - 17) / 2];
            send_item(REQ_TICK, 8'($urandom), 7'($urandom), sda);
        end
    endtask

    initial begin : stimulus
        logic       rd;
        logic [7:0] cmd;
        logic [6:0] wval;
        logic [7:0] rd_byte;
        int         dec;
        int         n_ticks;
        int         target;

        // Reset held low from the start, released on a falling edge.
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed ----
        // Tick and no-op kind while idle: pins stay at idle levels.
        send_item(REQ_TICK, 8'hFF, 7'h7F, 1'b1);
        send_item(REQ_NONE, 8'hFF, 7'h7F, 1'b1);
        // Write with all-ones command (bit 0 must clear) and value above 99.
        send_item(REQ_WRITE, 8'hFF, 7'd127, 1'b0);
        // Requests while busy are dropped.
        send_item(REQ_READ, 8'h00, 7'd0, 1'b1);
        send_item(REQ_NONE, 8'h00, 7'd0, 1'b0);
        clock_out(1'b0, 8'h00, TICKS_PER_TX, 0);
        // Read with all-zeros command (bit 0 must set); non-BCD byte 0xFF -> 165.
        send_item(REQ_READ, 8'h00, 7'd0, 1'b0);
        clock_out(1'b1, 8'hFF, TICKS_PER_TX, 0);
        // Tick right after done: idle again.
        send_item(REQ_TICK, 8'h00, 7'd0, 1'b0);

        // ---- random, three idling phases ----
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = sent_cnt + PHASE_ITEMS;
            while (sent_cnt < target) begin
                if ($urandom_range(0, 99) < 12) begin
                    // stray tick or no-op kind between accesses
                    send_item($urandom_range(0, 1) ? REQ_TICK : REQ_NONE, 8'($urandom),
                              7'($urandom), 1'($urandom));
                end else begin
                    rd   = 1'($urandom);
                    cmd  = 8'($urandom);
                    wval = ($urandom_range(0, 99) < 80) ? 7'($urandom_range(0, 99))
                                                        : 7'($urandom_range(0, 127));
                    dec  = $urandom_range(0, 99);
                    rd_byte = $urandom_range(0, 1) ? {4'(dec / 10), 4'(dec % 10)}
                                                   : 8'($urandom);
                    // mostly complete accesses, some cut short so the next
                    // request lands on a busy block
                    n_ticks = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 33)
                                                           : TICKS_PER_TX;
                    send_item(rd ? REQ_READ : REQ_WRITE, cmd, wval, 1'($urandom));
                    clock_out(rd, rd_byte, n_ticks, 8);
                end
            end
        end

        // ---- drain ----
        push <= 1'b0;
        recv_idle_pct = 0;
        while (pending != 0) @(negedge i_clk);
        // then allow for stray results before the verdict
        repeat (6) @(negedge i_clk);

        if (mismatch_cnt == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: three_wire_rtc_register_access.f
+incdir+hdl
hdl/rtcra_pkg.sv
hdl/rtcra_front.sv
hdl/rtcra_engine.sv
hdl/three_wire_rtc_register_access.sv
hdl/rtcra_checker.sv
bench/rtc_pin_sequence_checker.sv
bench/tb_three_wire_rtc_register_access.sv
